>>> hw/rtl/fmsc_pkg.sv
// Shared types and constants for the firmware identity marker scanner.
// No dependencies; every other file of the block imports this package.
package fmsc_pkg;

  // Fixed field widths of the byte and result channels
  localparam int BYTE_W        = 8;
  localparam int VER_LEN_W     = 5;
  localparam int PREFIX_W      = 64;
  localparam int PREFIX_LEN_W  = 4;
  localparam int PREFIX_MAX    = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PREFIX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREFIX_BYTES  = 1'b0,
    REG_PREFIX_LENGTH = 1'b1
  } cfg_reg_t;

  // Input function codes
  localparam logic FUNC_FEED  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Characters of the marker syntax
  localparam logic [BYTE_W-1:0] CH_BAR  = 8'h7C;
  localparam logic [BYTE_W-1:0] CH_DOT  = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

  typedef struct packed {
    logic                 found;
    logic                 char_valid;
    logic [BYTE_W-1:0]    version_char;
    logic [VER_LEN_W-1:0] version_length;
    logic                 last;
  } result_t;

  // Handshake between the scanner core and the result buffer
  typedef struct packed {
    logic    push;
    result_t data;
  } res_push_t;

endpackage

>>> hw/rtl/fmsc_in_if.sv
// Byte channel of the marker scanner: valid/ready plus function and byte.
// Depends on fmsc_pkg.
interface fmsc_in_if
  import fmsc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output func, output byte_value, input ready);
  modport sink   (input valid, input func, input byte_value, output ready);
endinterface

>>> hw/rtl/fmsc_out_if.sv
// Result channel of the marker scanner: valid/ready plus the result fields.
// Depends on fmsc_pkg.
interface fmsc_out_if
  import fmsc_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic                 char_valid;
  logic [BYTE_W-1:0]    version_char;
  logic [VER_LEN_W-1:0] version_length;
  logic                 last;

  modport source (output valid, output found, output char_valid, output version_char,
                  output version_length, output last, input ready);
  modport sink   (input valid, input found, input char_valid, input version_char,
                  input version_length, input last, output ready);
endinterface

>>> hw/rtl/fmsc_result_buffer.sv
// Output register with a skid stage for the scanner's result channel.
// Depends on fmsc_pkg and fmsc_out_if.
module fmsc_result_buffer
  import fmsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  res_push_t         push_in,
  output logic              space,
  fmsc_out_if.source        result_out
);

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (result_out.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push_in.push;
      end
    end else if (push_in.push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result_out.ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push_in.push) begin
        out_data <= push_in.data;
      end
    end else if (push_in.push) begin
      skid_data <= push_in.data;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.found          = out_data.found;
  assign result_out.char_valid     = out_data.char_valid;
  assign result_out.version_char   = out_data.version_char;
  assign result_out.version_length = out_data.version_length;
  assign result_out.last           = out_data.last;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  a_push_with_space: assert property (@(posedge clk) disable iff (rst)
    push_in.push |-> space)
    else $error("result pushed into a full buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && result_out.ready) |=> (out_valid && !skid_valid))
    else $error("skid entry not moved to output register");

endmodule

>>> hw/rtl/firmware_id_marker_scanner_unit.sv
// Firmware identity marker scanner, top level.
// Depends on fmsc_pkg, fmsc_in_if, fmsc_out_if and fmsc_result_buffer.
//
// Usage:
//   byte_in carries one transaction per stream byte (func = feed) or a clear
//   command (func = clear). result_out carries the results: one status
//   transaction per input, or, for the '|' that closes a valid marker, one
//   transaction per captured version character with last on the final one.
//   Configuration (prefix_bytes, prefix_length, where 0 acts as 1) uses cfg_we,
//   cfg_index, cfg_data; the user must write it only while the block is idle, which the block does not enforce.
// Flow:
//   A status result is registered in the output register, or in the skid entry
//   when result_out stalls. Ordinary bytes are taken one per cycle while the skid
//   entry is free. After the closing byte of a marker, byte_in is held until the
//   burst is done: it reads the version store one entry per cycle while result_out has space (single read port).
// Reset:
//   rst (synchronous) empties the result buffer, clears the match and
//   version counters and the found flag, and sets prefix_bytes to 0 and
//   prefix_length to 1. The version store is not cleared.
// Stalls:
//   An output register plus one skid entry sit on result_out; byte_in drops
//   ready only when the skid entry is in use or a burst is running.
module firmware_id_marker_scanner_unit
  import fmsc_pkg::*;
#(
  parameter int VERSION_MAX = 23
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fmsc_in_if.sink               byte_in,
  fmsc_out_if.source            result_out
);

  localparam int VW = $clog2(VERSION_MAX + 1);
  localparam int AW = (VERSION_MAX > 1) ? $clog2(VERSION_MAX) : 1;

  // Configuration registers
  logic [PREFIX_W-1:0]     prefix_bytes;
  logic [PREFIX_LEN_W-1:0] prefix_length;

  // Scan state
  logic [PREFIX_LEN_W-1:0] match_count, match_count_next;
  logic [VW-1:0]           version_count, version_count_next;
  logic                    found_flag, found_flag_next;
  logic [BYTE_W-1:0]       version_store [VERSION_MAX];

  // Burst engine: read issue stage and read data stage
  logic          burst_active, burst_active_next;
  logic [VW-1:0] rd_addr;
  logic          rd_issue;
  logic          rd_last;
  logic          data_valid;
  logic [BYTE_W-1:0] data_char;
  logic          data_last;
  logic          data_push;

  logic          accept;
  logic          space;
  logic          store_we;
  logic          status_push;
  logic          burst_start;
  logic [PREFIX_LEN_W-1:0] plen;
  logic [BYTE_W-1:0] first_char;
  logic [BYTE_W-1:0] cur_char;
  logic [BYTE_W-1:0] c;
  logic          is_ver_char;
  res_push_t     push_bus;

  // Configuration writes; the index decode covers every code
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_bytes  <= '0;
      prefix_length <= PREFIX_LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PREFIX_BYTES:  prefix_bytes  <= cfg_data;
        REG_PREFIX_LENGTH: prefix_length <= cfg_data[PREFIX_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept bytes unless a burst owns the result path or the skid entry is full
  assign byte_in.ready = !burst_active && !data_valid && space;
  assign accept        = byte_in.valid && byte_in.ready;
  assign c             = byte_in.byte_value;

  // Effective prefix length: zero acts as one, saturate at the maximum
  always_comb begin
    if (prefix_length == '0) begin
      plen = PREFIX_LEN_W'(1);
    end else if (prefix_length > PREFIX_LEN_W'(PREFIX_MAX)) begin
      plen = PREFIX_LEN_W'(PREFIX_MAX);
    end else begin
      plen = prefix_length;
    end
  end

  assign first_char  = prefix_bytes[BYTE_W-1:0];
  assign cur_char    = prefix_bytes[{match_count[2:0], 3'b000} +: BYTE_W];
  assign is_ver_char = ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_DOT);

  // Scan state update for one accepted transaction
  always_comb begin
    match_count_next   = match_count;
    version_count_next = version_count;
    found_flag_next    = found_flag;
    store_we           = 1'b0;
    burst_start        = 1'b0;
    if (accept) begin
      if (byte_in.func == FUNC_CLEAR) begin
        match_count_next   = '0;
        version_count_next = '0;
        found_flag_next    = 1'b0;
      end else if (found_flag) begin
        // marker already found: ignore the byte
      end else if (match_count < plen) begin
        if (c == cur_char) begin
          match_count_next = match_count + PREFIX_LEN_W'(1);
        end else begin
          match_count_next = (c == first_char) ? PREFIX_LEN_W'(1) : '0;
        end
        version_count_next = '0;
      end else if ((c == CH_BAR) && (version_count != '0)) begin
        found_flag_next = 1'b1;
        burst_start     = 1'b1;
      end else if (is_ver_char && (version_count < VW'(VERSION_MAX))) begin
        store_we           = 1'b1;
        version_count_next = version_count + VW'(1);
      end else begin
        // abandon the capture, restart on the first prefix byte
        match_count_next   = (c == first_char) ? PREFIX_LEN_W'(1) : '0;
        version_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count   <= '0;
      version_count <= '0;
      found_flag    <= 1'b0;
    end else begin
      match_count   <= match_count_next;
      version_count <= version_count_next;
      found_flag    <= found_flag_next;
    end
  end

  // Burst: issue one store read per cycle while the data stage can move on
  assign data_push = data_valid && space;
  assign rd_issue  = burst_active && (!data_valid || data_push);
  assign rd_last   = (rd_addr == (version_count - VW'(1)));

  always_comb begin
    burst_active_next = burst_active;
    if (burst_start) begin
      burst_active_next = 1'b1;
    end else if (rd_issue && rd_last) begin
      burst_active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_active <= 1'b0;
      rd_addr      <= '0;
      data_valid   <= 1'b0;
    end else begin
      burst_active <= burst_active_next;
      if (burst_start) begin
        rd_addr <= '0;
      end else if (rd_issue) begin
        rd_addr <= rd_addr + VW'(1);
      end
      if (rd_issue) begin
        data_valid <= 1'b1;
      end else if (data_push) begin
        data_valid <= 1'b0;
      end
    end
  end

  // Version store: one write port for capture, one registered read port for the burst
  always_ff @(posedge clk) begin
    if (store_we) begin
      version_store[version_count[AW-1:0]] <= c;
    end
    if (rd_issue) begin
      data_char <= version_store[rd_addr[AW-1:0]];
      data_last <= rd_last;
    end
  end

  // Result selection: burst characters or one status transaction per input other than a marker's closing byte
  assign status_push = accept && !burst_start;

  always_comb begin
    push_bus.push = status_push || data_push;
    if (data_push) begin
      push_bus.data.found          = 1'b1;
      push_bus.data.char_valid     = 1'b1;
      push_bus.data.version_char   = data_char;
      push_bus.data.version_length = VER_LEN_W'(version_count);
      push_bus.data.last           = data_last;
    end else begin
      push_bus.data.found          = found_flag_next;
      push_bus.data.char_valid     = 1'b0;
      push_bus.data.version_char   = '0;
      push_bus.data.version_length = VER_LEN_W'(version_count_next);
      push_bus.data.last           = 1'b1;
    end
  end

  fmsc_result_buffer u_result_buffer (
    .clk        (clk),
    .rst        (rst),
    .push_in    (push_bus),
    .space      (space),
    .result_out (result_out)
  );

  a_no_accept_in_burst: assert property (@(posedge clk) disable iff (rst)
    (burst_active || data_valid) |-> !byte_in.ready)
    else $error("byte accepted while a burst is running");

  a_version_bound: assert property (@(posedge clk) disable iff (rst)
    version_count <= VW'(VERSION_MAX))
    else $error("version count beyond maximum");

  a_found_starts_burst: assert property (@(posedge clk) disable iff (rst)
    $rose(found_flag) |-> burst_active)
    else $error("marker found without a character burst");

  a_burst_keeps_count: assert property (@(posedge clk) disable iff (rst)
    burst_active |=> $stable(version_count))
    else $error("version count changed during a burst");

endmodule
